@@ rtl/multi_alarm_weekday_matcher_defines.svh @@
// assertion macros for the alarm matcher checker
// expects clk and rst_n in the scope of every use
`ifndef MULTI_ALARM_WEEKDAY_MATCHER_DEFINES_SVH
`define MULTI_ALARM_WEEKDAY_MATCHER_DEFINES_SVH

// same-cycle implication
`define MAWM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alarm matcher check failed");

// next-cycle implication
`define MAWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alarm matcher check failed");

`endif

@@ rtl/mawm_pkg.sv @@
// types, codes and small tables for the multi-alarm weekday matcher
// no dependencies
package mawm_pkg;

  // request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_CHECK = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // day modes
  localparam logic [3:0] DAY_EACH    = 4'd7;
  localparam logic [3:0] DAY_ONCE    = 4'd8;
  localparam logic [3:0] DAY_WORK    = 4'd9;
  localparam logic [3:0] DAY_WEEKEND = 4'd10;

  // rounds reported for the long beep setting
  localparam logic [4:0] LONG_ROUNDS = 5'd20;

  // weekday bias, 525 - 2 folded mod 7
  localparam logic [7:0] WD_BIAS = 8'd5;

  typedef struct packed {
    logic       enabled;
    logic [3:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [1:0] pitch;
    logic [3:0] beeps;
  } alarm_entry_t;

  localparam alarm_entry_t ENTRY_DEFAULT = '{
    enabled: 1'b0, day: DAY_EACH, hour: 5'd0, minute: 6'd0, pitch: 2'd1, beeps: 4'd5
  };

  typedef struct packed {
    logic match;    // enabled and hour/minute equal
    logic day_hit;  // match and day mode hits today
    logic due;      // enabled and due within 24h
  } eval_res_t;

  // 13 * (m + 1) / 5 for the shifted month
  function automatic logic [5:0] month_term(input logic [3:0] m);
    logic [5:0] t;
    case (m)
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      4'd13:   t = 6'd36;
      4'd14:   t = 6'd39;
      4'd15:   t = 6'd41;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  function automatic logic min_is_mult12(input logic [5:0] mn);
    return (mn == 6'd0) || (mn == 6'd12) || (mn == 6'd24) ||
           (mn == 6'd36) || (mn == 6'd48) || (mn == 6'd60);
  endfunction

endpackage

@@ rtl/multi_alarm_weekday_matcher.sv @@
// multi-alarm weekday matcher: top level, sequencer and alarm table
// uses mawm_pkg, mawm_ram, mawm_weekday and mawm_eval
//
// usage:
// - an item is taken when start is high and busy is low; in_req_type picks
//   write entry, minute check or next-24h query
// - each item gives exactly one result, shown for one cycle with out_strobe;
//   the receiver cannot stall, so results are never held back
// - write, unknown request and a repeated minute check answer one cycle
//   after the item is taken; busy stays low, one item per cycle
// - any other minute check or a query scans the table through one shared
//   compare unit, one entry per cycle from a ram with registered read, and
//   the finish state that ends the scan registers the result; busy is high
//   through the scan and the finish state and the next item can be taken
//   in the cycle the result is shown
// - reset clears the valid bit of every entry (an entry never written reads
//   as disabled, each day, 00:00, pitch 1, beeps 5), the last handled minute
//   and the sequencer; no clearing pass is needed
module multi_alarm_weekday_matcher
  import mawm_pkg::*;
#(
  parameter int NUM_ALARMS      = 16,
  parameter int MAX_BEEP_ROUNDS = 11
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_req_type,
  input  logic [3:0] in_entry_index,
  input  logic       in_entry_enabled,
  input  logic [3:0] in_entry_day_mode,
  input  logic [1:0] in_entry_pitch,
  input  logic [3:0] in_entry_beeps,
  input  logic [5:0] in_year_offset,
  input  logic [3:0] in_month,
  input  logic [4:0] in_day_of_month,
  input  logic [4:0] in_hour,
  input  logic [5:0] in_minute,
  output logic       out_strobe,
  output logic       out_fire,
  output logic [3:0] out_alarm_index,
  output logic [1:0] out_pitch,
  output logic [4:0] out_beep_rounds,
  output logic       out_active_valid,
  output logic       out_any_active
);

  // table address, counter and entry widths
  localparam int AW = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
  localparam int CW = $clog2(NUM_ALARMS + 1);
  localparam int EW = $bits(alarm_entry_t);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CW-1:0]         rd_cnt_r, rd_cnt_nxt;
  logic                  ev_vld_r, ev_vld_nxt;
  logic [AW-1:0]         ev_idx_r, ev_idx_nxt;
  logic [NUM_ALARMS-1:0] valid_r, valid_nxt;
  logic                  last_vld_r, last_vld_nxt;
  logic [5:0]            last_min_r, last_min_nxt;
  logic [1:0]            req_r, req_nxt;
  logic [4:0]            hr_r, hr_nxt;
  logic [5:0]            mn_r, mn_nxt;
  logic [2:0]            wd_r, wd_nxt;
  logic [AW-1:0]         play_idx_r, play_idx_nxt;
  alarm_entry_t          play_ent_r, play_ent_nxt;
  logic                  play_due_r, play_due_nxt;
  logic                  fire_acc_r, fire_acc_nxt;
  logic [CW-1:0]         due_cnt_r, due_cnt_nxt;

  logic                  out_strobe_nxt;
  logic                  out_fire_r, out_fire_nxt;
  logic [3:0]            out_idx_r, out_idx_nxt;
  logic [1:0]            out_pitch_r, out_pitch_nxt;
  logic [4:0]            out_beeps_r, out_beeps_nxt;
  logic                  out_av_r, out_av_nxt;
  logic                  out_any_r, out_any_nxt;
  logic                  out_strobe_r;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  alarm_entry_t          ram_wdata;
  logic [EW-1:0]         ram_q;
  logic [2:0]            wd_in;
  alarm_entry_t          ev_ent;
  eval_res_t             ev_res;
  logic                  idx_in_range;

  // alarm table; entries whose valid bit is clear read as the default entry
  mawm_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_ALARMS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_cnt_r[AW-1:0]),
    .rdata (ram_q)
  );

  // weekday is taken from the item's date when it is accepted
  mawm_weekday u_weekday (
    .year_offset  (in_year_offset),
    .month        (in_month),
    .day_of_month (in_day_of_month),
    .weekday      (wd_in)
  );

  // one compare unit, fed one entry per scan cycle
  mawm_eval u_eval (
    .entry   (ev_ent),
    .weekday (wd_r),
    .hour    (hr_r),
    .minute  (mn_r),
    .res     (ev_res)
  );

  assign ev_ent       = valid_r[ev_idx_r] ? alarm_entry_t'(ram_q) : ENTRY_DEFAULT;
  assign idx_in_range = (int'(in_entry_index) < NUM_ALARMS);
  assign ram_waddr    = AW'(in_entry_index);
  assign ram_wdata    = '{enabled: in_entry_enabled, day: in_entry_day_mode,
                          hour: in_hour, minute: in_minute,
                          pitch: in_entry_pitch, beeps: in_entry_beeps};

  always_comb begin
    state_nxt      = state_r;
    rd_cnt_nxt     = rd_cnt_r;
    ev_vld_nxt     = 1'b0;
    ev_idx_nxt     = ev_idx_r;
    valid_nxt      = valid_r;
    last_vld_nxt   = last_vld_r;
    last_min_nxt   = last_min_r;
    req_nxt        = req_r;
    hr_nxt         = hr_r;
    mn_nxt         = mn_r;
    wd_nxt         = wd_r;
    play_idx_nxt   = play_idx_r;
    play_ent_nxt   = play_ent_r;
    play_due_nxt   = play_due_r;
    fire_acc_nxt   = fire_acc_r;
    due_cnt_nxt    = due_cnt_r;
    ram_we         = 1'b0;
    // result payload is zero unless a case below fills it in
    out_strobe_nxt = 1'b0;
    out_fire_nxt   = 1'b0;
    out_idx_nxt    = 4'd0;
    out_pitch_nxt  = 2'd0;
    out_beeps_nxt  = 5'd0;
    out_av_nxt     = 1'b0;
    out_any_nxt    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt      = in_req_type;
          hr_nxt       = in_hour;
          mn_nxt       = in_minute;
          wd_nxt       = wd_in;
          rd_cnt_nxt   = '0;
          fire_acc_nxt = 1'b0;
          due_cnt_nxt  = '0;
          play_due_nxt = 1'b0;
          case (in_req_type)
            REQ_WRITE: begin
              // out-of-range index is dropped, result still given
              if (idx_in_range) begin
                ram_we               = 1'b1;
                valid_nxt[ram_waddr] = 1'b1;
              end
              out_strobe_nxt = 1'b1;
            end
            REQ_CHECK: begin
              if (last_vld_r && (last_min_r == in_minute)) begin
                // minute already handled
                out_strobe_nxt = 1'b1;
              end else begin
                last_vld_nxt = 1'b1;
                last_min_nxt = in_minute;
                state_nxt    = ST_SCAN;
              end
            end
            REQ_QUERY: begin
              state_nxt = ST_SCAN;
            end
            default: begin
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // read side: one table address per cycle
        if (rd_cnt_r != CW'(NUM_ALARMS)) begin
          rd_cnt_nxt = rd_cnt_r + CW'(1);
          ev_vld_nxt = 1'b1;
          ev_idx_nxt = rd_cnt_r[AW-1:0];
        end
        // compare side: sees the entry read in the cycle before
        if (ev_vld_r) begin
          if (ev_res.match) begin
            // last matching entry is the one that plays
            play_idx_nxt = ev_idx_r;
            play_ent_nxt = ev_ent;
            play_due_nxt = ev_res.due;
          end
          if (ev_res.day_hit) begin
            fire_acc_nxt = 1'b1;
          end
          if (ev_res.due) begin
            due_cnt_nxt = due_cnt_r + CW'(1);
          end
          if (ev_idx_r == AW'(NUM_ALARMS - 1)) begin
            state_nxt = ST_FIN;
          end
        end
      end

      ST_FIN: begin
        state_nxt      = ST_IDLE;
        out_strobe_nxt = 1'b1;
        if (req_r == REQ_QUERY) begin
          out_av_nxt  = 1'b1;
          out_any_nxt = (due_cnt_r != '0);
        end else if (fire_acc_r) begin
          out_fire_nxt  = 1'b1;
          out_idx_nxt   = 4'(play_idx_r);
          out_pitch_nxt = play_ent_r.pitch;
          out_beeps_nxt = (play_ent_r.beeps == 4'(MAX_BEEP_ROUNDS - 1)) ?
                          LONG_ROUNDS : 5'(play_ent_r.beeps);
          if (play_ent_r.day == DAY_ONCE) begin
            // one-time entry goes back to defaults, which are disabled,
            // so it drops out of the due count
            valid_nxt[play_idx_r] = 1'b0;
            out_av_nxt  = 1'b1;
            out_any_nxt = ((due_cnt_r - CW'(play_due_r)) != '0);
          end
        end else begin
          // quiet minute: allow a later check of the same minute
          last_vld_nxt = 1'b0;
          if (min_is_mult12(mn_r)) begin
            out_av_nxt  = 1'b1;
            out_any_nxt = (due_cnt_r != '0);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ev_vld_r     <= 1'b0;
      valid_r      <= '0;
      last_vld_r   <= 1'b0;
      play_idx_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ev_vld_r     <= ev_vld_nxt;
      valid_r      <= valid_nxt;
      last_vld_r   <= last_vld_nxt;
      play_idx_r   <= play_idx_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    rd_cnt_r    <= rd_cnt_nxt;
    ev_idx_r    <= ev_idx_nxt;
    last_min_r  <= last_min_nxt;
    req_r       <= req_nxt;
    hr_r        <= hr_nxt;
    mn_r        <= mn_nxt;
    wd_r        <= wd_nxt;
    play_ent_r  <= play_ent_nxt;
    play_due_r  <= play_due_nxt;
    fire_acc_r  <= fire_acc_nxt;
    due_cnt_r   <= due_cnt_nxt;
    out_fire_r  <= out_fire_nxt;
    out_idx_r   <= out_idx_nxt;
    out_pitch_r <= out_pitch_nxt;
    out_beeps_r <= out_beeps_nxt;
    out_av_r    <= out_av_nxt;
    out_any_r   <= out_any_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_strobe       = out_strobe_r;
  assign out_fire         = out_fire_r;
  assign out_alarm_index  = out_idx_r;
  assign out_pitch        = out_pitch_r;
  assign out_beep_rounds  = out_beeps_r;
  assign out_active_valid = out_av_r;
  assign out_any_active   = out_any_r;

endmodule

@@ rtl/mawm_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module mawm_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/mawm_weekday.sv @@
// weekday from the calendar date, monday is 0
// uses mawm_pkg for the month term table
module mawm_weekday
  import mawm_pkg::*;
(
  input  logic [5:0] year_offset,
  input  logic [3:0] month,
  input  logic [4:0] day_of_month,
  output logic [2:0] weekday
);

  logic       early;
  logic [3:0] m_adj;
  logic [6:0] y;
  logic [7:0] sum;
  logic [4:0] fold1;
  logic [3:0] fold2;

  always_comb begin
    early = (month <= 4'd2);
    m_adj = early ? month + 4'd12 : month;
    y     = 7'(year_offset) + 7'd20 - (early ? 7'd1 : 7'd0);
    sum   = 8'(day_of_month) + 8'(month_term(m_adj)) + 8'(y) + 8'(y >> 2) + WD_BIAS;
    // 8 is 1 mod 7, so octal digits can be summed
    fold1 = 5'(sum[2:0]) + 5'(sum[5:3]) + 5'(sum[7:6]);
    fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
    weekday = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
  end

endmodule

@@ rtl/mawm_eval.sv @@
// per-entry compare unit, reused for every entry during a table scan
// uses mawm_pkg for the entry layout and day mode codes
module mawm_eval
  import mawm_pkg::*;
(
  input  alarm_entry_t entry,
  input  logic [2:0]   weekday,
  input  logic [4:0]   hour,
  input  logic [5:0]   minute,
  output eval_res_t    res
);

  logic [10:0] now_min;
  logic [10:0] at_min;
  logic [3:0]  wd;
  logic [3:0]  wd_next;
  logic        ge;
  logic        le;
  logic        any_day;

  always_comb begin
    now_min = 11'(hour) * 11'd60 + 11'(minute);
    at_min  = 11'(entry.hour) * 11'd60 + 11'(entry.minute);
    wd      = {1'b0, weekday};
    wd_next = (weekday == 3'd6) ? 4'd0 : wd + 4'd1;
    ge      = (at_min >= now_min);
    le      = (at_min <= now_min);
    any_day = (entry.day == DAY_EACH) || (entry.day == DAY_ONCE);

    res.match = entry.enabled && (entry.hour == hour) && (entry.minute == minute);
    res.day_hit = res.match &&
      (any_day || (entry.day == wd) ||
       ((entry.day == DAY_WORK) && (weekday < 3'd5)) ||
       ((entry.day == DAY_WEEKEND) && (weekday >= 3'd5)));
    res.due = entry.enabled &&
      (any_day ||
       ((entry.day == wd) && ge) ||
       ((entry.day == wd_next) && le) ||
       ((entry.day == DAY_WORK) &&
        ((weekday < 3'd4) || ((weekday == 3'd4) && ge) || ((weekday == 3'd6) && le))) ||
       ((entry.day == DAY_WEEKEND) &&
        ((weekday == 3'd5) || ((weekday == 3'd6) && ge) || ((weekday == 3'd4) && le))));
  end

endmodule

@@ rtl/mawm_checker.sv @@
// port-level checks for the multi-alarm weekday matcher, bound to the top
// uses the assertion macros from multi_alarm_weekday_matcher_defines.svh
`include "multi_alarm_weekday_matcher_defines.svh"

module mawm_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input logic out_fire
);

  // an accepted item either answers next cycle or keeps the block busy
  `MAWM_ASSERT_NEXT(a_accept_progress, start && !busy, out_strobe || busy)
  // end of a scan always delivers its result
  `MAWM_ASSERT_IMPL(a_scan_done_strobe, $fell(busy), out_strobe)
  // no result is shown while a scan runs
  `MAWM_ASSERT_IMPL(a_no_strobe_busy, busy, !out_strobe)
  // a fire only comes out of a table scan
  `MAWM_ASSERT_IMPL(a_fire_after_scan, out_strobe && out_fire, $past(busy))

endmodule

bind multi_alarm_weekday_matcher mawm_checker u_mawm_checker (.*);

@@ test/tb_multi_alarm_weekday_matcher.sv @@
`timescale 1ns / 1ps
// self-checking bench for multi_alarm_weekday_matcher: a queue-fed driver, a result monitor
// and a cycle-free alarm table model; needs mawm_pkg and the matcher rtl
module tb_multi_alarm_weekday_matcher;
  import mawm_pkg::*;

  localparam int ALARM_COUNT = 16;
  localparam int BEEP_SETTINGS = 11;
  localparam logic [1:0] REQ_UNUSED = 2'd3;  // request code the block ignores
  localparam int END_DRAIN = 40;             // cycles watched after the last result
  localparam int TIMEOUT_NS = 5_000_000;

  // one pending item; hold marks a pause until every result is back
  typedef struct {
    bit         hold;
    int         idle_pct;
    logic [1:0] req;
    logic [3:0] idx;
    logic       en;
    logic [3:0] day;
    logic [1:0] pitch;
    logic [3:0] beeps;
    logic [5:0] yoff;
    logic [3:0] mon;
    logic [4:0] dom;
    logic [4:0] hr;
    logic [5:0] mn;
  } alarm_req_t;

  typedef struct packed {
    logic       fire;
    logic [3:0] idx;
    logic [1:0] pitch;
    logic [4:0] rounds;
    logic       act_valid;
    logic       any_act;
  } alarm_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_req_type = '0;
  logic [3:0] in_entry_index = '0;
  logic       in_entry_enabled = 1'b0;
  logic [3:0] in_entry_day_mode = '0;
  logic [1:0] in_entry_pitch = '0;
  logic [3:0] in_entry_beeps = '0;
  logic [5:0] in_year_offset = '0;
  logic [3:0] in_month = '0;
  logic [4:0] in_day_of_month = '0;
  logic [4:0] in_hour = '0;
  logic [5:0] in_minute = '0;
  logic       out_strobe;
  logic       out_fire;
  logic [3:0] out_alarm_index;
  logic [1:0] out_pitch;
  logic [4:0] out_beep_rounds;
  logic       out_active_valid;
  logic       out_any_active;

  multi_alarm_weekday_matcher #(
    .NUM_ALARMS     (ALARM_COUNT),
    .MAX_BEEP_ROUNDS(BEEP_SETTINGS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_entry_index   (in_entry_index),
    .in_entry_enabled (in_entry_enabled),
    .in_entry_day_mode(in_entry_day_mode),
    .in_entry_pitch   (in_entry_pitch),
    .in_entry_beeps   (in_entry_beeps),
    .in_year_offset   (in_year_offset),
    .in_month         (in_month),
    .in_day_of_month  (in_day_of_month),
    .in_hour          (in_hour),
    .in_minute        (in_minute),
    .out_strobe       (out_strobe),
    .out_fire         (out_fire),
    .out_alarm_index  (out_alarm_index),
    .out_pitch        (out_pitch),
    .out_beep_rounds  (out_beep_rounds),
    .out_active_valid (out_active_valid),
    .out_any_active   (out_any_active)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // alarm table model: its own copy of the entries, the handled minute and the
  // entry last chosen to play
  // ---------------------------------------------------------------------------
  alarm_entry_t alarm_tbl [ALARM_COUNT];
  bit           minute_latched_valid;
  logic [5:0]   minute_latched;
  int           playing_entry;

  // run statistics
  int n_writes, n_checks, n_queries, n_ignored;
  int fires_seen, reports_seen, due_seen;
  int fail_count;

  // pending items, expected results and the handshake counters
  alarm_req_t    pend_q [$];
  alarm_result_t expected_results_q [$];
  alarm_req_t    cur_req;
  int            items_taken;
  int            results_seen;
  int            total_items;
  int            sender_idle_pct;

  // zeller-style congruence, monday is 0; jan and feb count as months 13 and 14
  // of the year before, and month 0 as month 12 of the year before
  function automatic int day_of_week(logic [5:0] yoff, logic [3:0] mon, logic [4:0] dom);
    int y;
    int m;
    y = int'(yoff) + 20;
    m = int'(mon);
    if (m <= 2) begin
      m += 12;
      y -= 1;
    end
    return (int'(dom) + 13 * (m + 1) / 5 + y + y / 4 + 523) % 7;
  endfunction

  // true when some enabled entry goes off within the next 24 hours
  function automatic bit alarm_due_within_day(int wd, logic [4:0] hr, logic [5:0] mn);
    int now_min;
    int at_min;
    int d;
    now_min = int'(hr) * 60 + int'(mn);
    foreach (alarm_tbl[i]) begin
      if (!alarm_tbl[i].enabled) continue;
      d = int'(alarm_tbl[i].day);
      if (d == DAY_EACH || d == DAY_ONCE) return 1'b1;
      at_min = int'(alarm_tbl[i].hour) * 60 + int'(alarm_tbl[i].minute);
      // today later on, or tomorrow no later than now
      if (d == wd && at_min >= now_min) return 1'b1;
      if ((wd + 1) % 7 == d && at_min <= now_min) return 1'b1;
      // workday: mon-thu always, fri before the time, sun after it
      if (d == DAY_WORK && (wd < 4 || (wd == 4 && at_min >= now_min) ||
                            (wd == 6 && at_min <= now_min))) return 1'b1;
      // weekend: saturday always, sunday before the time, friday after it
      if (d == DAY_WEEKEND && (wd == 5 || (wd == 6 && at_min >= now_min) ||
                               (wd == 4 && at_min <= now_min))) return 1'b1;
    end
    return 1'b0;
  endfunction

  // expected result of one item; updates the model state
  function automatic alarm_result_t predict_alarm_result(alarm_req_t r);
    alarm_result_t res;
    int            wd;
    int            d;
    bit            fired;
    res   = '0;
    fired = 1'b0;
    wd    = day_of_week(r.yoff, r.mon, r.dom);
    case (r.req)
      REQ_WRITE: begin
        n_writes++;
        alarm_tbl[r.idx] = '{enabled: r.en, day: r.day, hour: r.hr, minute: r.mn,
                             pitch: r.pitch, beeps: r.beeps};
      end
      REQ_QUERY: begin
        n_queries++;
        res.act_valid = 1'b1;
        res.any_act   = alarm_due_within_day(wd, r.hr, r.mn);
      end
      REQ_CHECK: begin
        n_checks++;
        // a minute already handled gives an all-zero result
        if (!(minute_latched_valid && minute_latched == r.mn)) begin
          minute_latched_valid = 1'b1;
          minute_latched       = r.mn;
          // last time match plays, any matching day mode arms the fire
          foreach (alarm_tbl[i]) begin
            if (alarm_tbl[i].enabled && alarm_tbl[i].minute == r.mn &&
                alarm_tbl[i].hour == r.hr) begin
              playing_entry = i;
              d = int'(alarm_tbl[i].day);
              if (d == DAY_EACH || d == DAY_ONCE || d == wd) fired = 1'b1;
              if (d == DAY_WORK && wd < 5) fired = 1'b1;
              if (d == DAY_WEEKEND && wd >= 5) fired = 1'b1;
            end
          end
          if (fired) begin
            res.fire   = 1'b1;
            res.idx    = playing_entry[3:0];
            res.pitch  = alarm_tbl[playing_entry].pitch;
            res.rounds = (alarm_tbl[playing_entry].beeps == BEEP_SETTINGS - 1) ?
                         LONG_ROUNDS : {1'b0, alarm_tbl[playing_entry].beeps};
            // a one-time alarm is erased once it has played
            if (alarm_tbl[playing_entry].day == DAY_ONCE) begin
              alarm_tbl[playing_entry] = ENTRY_DEFAULT;
              res.act_valid = 1'b1;
              res.any_act   = alarm_due_within_day(wd, r.hr, r.mn);
            end
          end else begin
            minute_latched_valid = 1'b0;
            if (r.mn % 12 == 0) begin
              res.act_valid = 1'b1;
              res.any_act   = alarm_due_within_day(wd, r.hr, r.mn);
            end
          end
        end
      end
      default: n_ignored++;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------
  // every field but hold and idle_pct random over its full width
  function automatic alarm_req_t rand_item();
    alarm_req_t r;
    r.hold     = 1'b0;
    r.idle_pct = sender_idle_pct;
    r.req      = 2'($urandom);
    r.idx      = 4'($urandom);
    r.en       = 1'($urandom);
    r.day      = 4'($urandom);
    r.pitch    = 2'($urandom);
    r.beeps    = 4'($urandom);
    r.yoff     = 6'($urandom);
    r.mon      = 4'($urandom);
    r.dom      = 5'($urandom);
    r.hr       = 5'($urandom);
    r.mn       = 6'($urandom);
    return r;
  endfunction

  function automatic alarm_req_t time_item(logic [1:0] req, logic [5:0] yoff, logic [3:0] mon,
                                           logic [4:0] dom, logic [4:0] hr, logic [5:0] mn);
    alarm_req_t r;
    r      = rand_item();
    r.req  = req;
    r.yoff = yoff;
    r.mon  = mon;
    r.dom  = dom;
    r.hr   = hr;
    r.mn   = mn;
    return r;
  endfunction

  function automatic alarm_req_t write_item(logic [3:0] idx, logic en, logic [3:0] day,
                                            logic [1:0] pitch, logic [3:0] beeps,
                                            logic [4:0] hr, logic [5:0] mn);
    alarm_req_t r;
    r       = rand_item();
    r.req   = REQ_WRITE;
    r.idx   = idx;
    r.en    = en;
    r.day   = day;
    r.pitch = pitch;
    r.beeps = beeps;
    r.hr    = hr;
    r.mn    = mn;
    return r;
  endfunction

  // mostly calendar dates, now and then a date outside the calendar
  function automatic alarm_req_t dated_item(logic [1:0] req, logic [4:0] hr, logic [5:0] mn);
    logic [3:0] mon;
    logic [4:0] dom;
    mon = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(12, 1));
    dom = ($urandom_range(19) == 0) ? 5'd0 : 5'($urandom_range(31, 1));
    return time_item(req, 6'($urandom_range(63)), mon, dom, hr, mn);
  endfunction

  task automatic push_item(alarm_req_t r);
    pend_q.push_back(r);
    total_items++;
  endtask

  task automatic push_hold();
    alarm_req_t r;
    r      = rand_item();
    r.hold = 1'b1;
    pend_q.push_back(r);
  endtask

  task automatic queue_directed();
    // query right after reset, nothing enabled
    push_item(time_item(REQ_QUERY, 6'd0, 4'd1, 5'd1, 5'd0, 6'd0));
    // one-time alarm with the long beep setting: fires, is erased, reports 24h status
    push_item(write_item(4'd15, 1'b1, DAY_ONCE, 2'd2, 4'(BEEP_SETTINGS - 1), 5'd7, 6'd30));
    push_item(time_item(REQ_CHECK, 6'd4, 4'd3, 5'd15, 5'd7, 6'd30));
    // same minute again is ignored
    push_item(time_item(REQ_CHECK, 6'd4, 4'd3, 5'd15, 5'd7, 6'd30));
    // day hits on entry 0 but the later entry 3 is the one that plays
    push_item(write_item(4'd0, 1'b1, DAY_EACH, 2'd0, 4'd0, 5'd0, 6'd0));
    push_item(write_item(4'd3, 1'b1, 4'd2, 2'd3, 4'd15, 5'd0, 6'd0));
    push_item(time_item(REQ_CHECK, 6'd4, 4'd1, 5'd1, 5'd0, 6'd0));
    // workday and weekend entries on saturday and wednesday
    push_item(write_item(4'd5, 1'b1, DAY_WORK, 2'd1, 4'd9, 5'd12, 6'd5));
    push_item(write_item(4'd6, 1'b1, DAY_WEEKEND, 2'd2, 4'd1, 5'd12, 6'd6));
    push_item(time_item(REQ_CHECK, 6'd4, 4'd1, 5'd6, 5'd12, 6'd5));
    push_item(time_item(REQ_CHECK, 6'd4, 4'd1, 5'd6, 5'd12, 6'd6));
    push_item(time_item(REQ_CHECK, 6'd4, 4'd1, 5'd3, 5'd12, 6'd5));
    push_item(time_item(REQ_QUERY, 6'd4, 4'd1, 5'd5, 5'd23, 6'd59));
    // unknown request code
    push_item(time_item(REQ_UNUSED, 6'd63, 4'd15, 5'd31, 5'd31, 6'd63));
    // disabled entry never fires
    push_item(write_item(4'd1, 1'b0, DAY_EACH, 2'd1, 4'd5, 5'd5, 6'd5));
    push_item(time_item(REQ_CHECK, 6'd10, 4'd6, 5'd20, 5'd5, 6'd5));
    // day mode beyond weekend never fires, quiet minute 24 reports
    push_item(write_item(4'd2, 1'b1, 4'd12, 2'd1, 4'd3, 5'd10, 6'd24));
    push_item(time_item(REQ_CHECK, 6'd10, 4'd6, 5'd21, 5'd10, 6'd24));
    // all-ones entry fields and an out-of-calendar date
    push_item(write_item(4'd15, 1'b1, 4'd15, 2'd3, 4'd15, 5'd31, 6'd63));
    push_item(time_item(REQ_CHECK, 6'd63, 4'd15, 5'd31, 5'd31, 6'd63));
    push_item(time_item(REQ_QUERY, 6'd0, 4'd0, 5'd0, 5'd0, 6'd0));
    // leap-day february and a quiet multiple-of-12 minute
    push_item(time_item(REQ_CHECK, 6'd8, 4'd2, 5'd29, 5'd0, 6'd48));
  endtask

  // one random scenario: program a few entries at a shared time, then check it
  task automatic queue_scenario();
    alarm_req_t r;
    logic [4:0] hr;
    logic [5:0] mn;
    logic [3:0] day;
    logic [3:0] beeps;
    // sometimes wipe the table or a few entries so any_active can go low
    if ($urandom_range(99) < 3) begin
      for (int i = 0; i < ALARM_COUNT; i++)
        push_item(write_item(4'(i), 1'b0, 4'($urandom), 2'($urandom), 4'($urandom),
                             5'($urandom), 6'($urandom)));
    end else if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(4, 1))
        push_item(write_item(4'($urandom), 1'b0, 4'($urandom), 2'($urandom), 4'($urandom),
                             5'($urandom), 6'($urandom)));
    end
    hr = ($urandom_range(19) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(23));
    mn = ($urandom_range(19) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(59));
    repeat ($urandom_range(3, 1)) begin
      day   = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(10));
      beeps = ($urandom_range(3) == 0) ? 4'(BEEP_SETTINGS - 1) : 4'($urandom_range(15));
      push_item(write_item(4'($urandom), $urandom_range(9) != 0, day, 2'($urandom), beeps,
                           hr, mn));
    end
    if ($urandom_range(3) == 0)
      push_item(dated_item(REQ_QUERY, 5'($urandom_range(23)), 6'($urandom_range(59))));
    r = dated_item(REQ_CHECK, hr, mn);
    push_item(r);
    // repeat the same minute half of the time
    if ($urandom_range(1)) push_item(r);
    if ($urandom_range(3) == 0)
      push_item(dated_item(REQ_CHECK, 5'($urandom_range(23)), 6'(12 * $urandom_range(4))));
    if ($urandom_range(6) == 0)
      repeat ($urandom_range(2, 1)) push_item(rand_item());
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued items, predicts each one as it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    bit took;
    bit go;
    int in_flight;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        expected_results_q.push_back(predict_alarm_result(cur_req));
        items_taken <= items_taken + 1;
      end
      // free to change the inputs only when nothing is on offer
      if (took || !start) begin
        in_flight = items_taken + int'(took) - results_seen;
        // a hold marker stays until every result is back
        while (pend_q.size() > 0 && pend_q[0].hold && in_flight == 0) void'(pend_q.pop_front());
        go = pend_q.size() > 0 && !pend_q[0].hold &&
             ($urandom_range(99) >= pend_q[0].idle_pct);
        if (go) begin
          cur_req = pend_q.pop_front();
          in_req_type       <= cur_req.req;
          in_entry_index    <= cur_req.idx;
          in_entry_enabled  <= cur_req.en;
          in_entry_day_mode <= cur_req.day;
          in_entry_pitch    <= cur_req.pitch;
          in_entry_beeps    <= cur_req.beeps;
          in_year_offset    <= cur_req.yoff;
          in_month          <= cur_req.mon;
          in_day_of_month   <= cur_req.dom;
          in_hour           <= cur_req.hr;
          in_minute         <= cur_req.mn;
        end
        start <= go;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every strobe is matched against the oldest expectation
  // ---------------------------------------------------------------------------
  // four-state compare so an unknown bit on a result port is caught
  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    alarm_result_t want;
    if (rst_n && out_strobe) begin
      // old counter values: only items taken at earlier edges can answer now
      if (results_seen >= items_taken) begin
        $error("result with no item pending");
        fail_count++;
      end else begin
        want = expected_results_q.pop_front();
        compare_field("fire", 32'(want.fire), 32'(out_fire));
        compare_field("alarm_index", 32'(want.idx), 32'(out_alarm_index));
        compare_field("pitch", 32'(want.pitch), 32'(out_pitch));
        compare_field("beep_rounds", 32'(want.rounds), 32'(out_beep_rounds));
        compare_field("active_valid", 32'(want.act_valid), 32'(out_active_valid));
        compare_field("any_active", 32'(want.any_act), 32'(out_any_active));
        fires_seen   += int'(want.fire);
        reports_seen += int'(want.act_valid);
        due_seen     += int'(want.any_act);
        results_seen <= results_seen + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: fill the item queue, release reset, drain and report
  // ---------------------------------------------------------------------------
  initial begin
    foreach (alarm_tbl[i]) alarm_tbl[i] = ENTRY_DEFAULT;
    minute_latched_valid = 1'b0;
    minute_latched       = '0;
    playing_entry        = 0;

    // sender idles now and then in the first phase, then heavily, then never
    sender_idle_pct = 21;
    queue_directed();
    push_hold();
    while (total_items < 400) queue_scenario();
    push_hold();
    sender_idle_pct = 76;
    while (total_items < 780) queue_scenario();
    push_hold();
    sender_idle_pct = 0;
    while (total_items < 1150) queue_scenario();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    wait (items_taken == total_items);
    wait (results_seen == items_taken);
    repeat (END_DRAIN) @(posedge clk);

    $display("covered %0d items: %0d writes, %0d minute checks, %0d queries, %0d ignored",
             items_taken, n_writes, n_checks, n_queries, n_ignored);
    $display("%0d alarms fired, %0d next-24h reports, %0d of them with an alarm due",
             fires_seen, reports_seen, due_seen);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule
